// File: rtl/bouncing_ball_led_positions_defines.svh
// Assertion macros for the bouncing ball position generator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BOUNCING_BALL_LED_POSITIONS_DEFINES_SVH
`define BOUNCING_BALL_LED_POSITIONS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bbl_pkg.sv
// Shared types and fixed-point constants of the bouncing ball position generator.
// No dependencies.
package bbl_pkg;

  typedef logic [17:0] vel_t;   // Q2.16 velocity
  typedef logic [31:0] ms_t;    // millisecond time

  typedef struct packed {
    vel_t vel;
    ms_t  strike;
  } ball_rec_t;

  // per-ball result of the arithmetic pipe, with the state to write back
  typedef struct packed {
    ball_rec_t  rec;
    logic [7:0] pos;
  } calc_res_t;

  localparam vel_t         V_LAUNCH   = 18'd92682;   // sqrt(2) in Q2.16
  localparam vel_t         V_RELAUNCH = 18'd6554;    // below this (0.1) relaunch
  localparam int unsigned  COR_BASE   = 58982;       // 0.90 in Q0.16
  localparam logic [16:0]  H_MAX      = 17'd131071;
  // t*(2000v - 65536t) at or above this saturates the height
  localparam logic [41:0]  H_SAT_PROD = 42'd262144000000;
  // divide by 2000000 = (x >> 7) / 15625, with 15625 done by reciprocal
  localparam logic [31:0]  DIV_M      = 32'd2251799813;  // floor(2^45 / 15625)
  localparam logic [30:0]  DIV_D      = 31'd15625;
  localparam logic [7:0]   HUE_STEP   = 8'd40;

endpackage

// File: rtl/bbl_tick_if.sv
// Tick channel: valid/ready handshake carrying the millisecond time.
// No dependencies.
interface bbl_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// File: rtl/bbl_ball_if.sv
// Ball result channel: valid/ready handshake carrying one ball position.
// No dependencies.
interface bbl_ball_if;
  logic       valid;
  logic       ready;
  logic [2:0] ball_index;
  logic [7:0] led_position;
  logic [7:0] hue;
  logic       last;

  modport source (output valid, output ball_index, output led_position, output hue,
                  output last, input ready);
  modport sink   (input valid, input ball_index, input led_position, input hue,
                  input last, output ready);
endinterface

// File: rtl/bouncing_ball_led_positions.sv
// Bouncing ball LED positions: per tick, one result per active ball, each ball
// in turn going through memory read, five-stage arithmetic pipe, emit and
// write-back; the emit waits while the result side stalls. The first tick
// after reset first sweeps the state memory, all BALLS_MAX entries. A new tick is
// taken as soon as the last ball result sits in the output register.
`include "bouncing_ball_led_positions_defines.svh"

module bouncing_ball_led_positions #(
  parameter int unsigned BALLS_MAX = 8,
  parameter int unsigned LED_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_data_i,
  bbl_tick_if.sink          in_i,
  bbl_ball_if.source        out_o
);
  import bbl_pkg::*;

  localparam int unsigned AW     = (BALLS_MAX > 1) ? $clog2(BALLS_MAX) : 1;
  localparam int unsigned BallCap = (BALLS_MAX < 8) ? BALLS_MAX : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e      state_q;
  logic [3:0]  ball_count_q;
  ms_t         now_q;
  logic [3:0]  n_q;
  logic [2:0]  ball_q;
  logic [AW-1:0] swp_q;
  logic        started_q;
  logic        rd_pend_q;
  logic        out_vld_q;
  logic [2:0]  out_ball_q;
  logic [7:0]  out_pos_q;
  logic [7:0]  out_hue_q;
  logic        out_last_q;

  logic        in_fire, emit_fire, is_last;
  logic [3:0]  n_sat;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  ball_rec_t   mem_wdata, mem_rdata;
  logic        calc_vld;
  calc_res_t   calc_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_count_q <= 4'd8;
    end else if (cfg_we_i) begin
      ball_count_q <= cfg_data_i;
    end
  end

  assign n_sat     = (ball_count_q > 4'(BallCap)) ? 4'(BallCap) : ball_count_q;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && (state_q == S_IDLE);
  assign emit_fire = (state_q == S_EMIT) && (!out_vld_q || out_o.ready);
  assign is_last   = ({1'b0, ball_q} + 4'd1) == n_q;

  // writes: init sweep, or write-back of the ball being emitted
  assign mem_we    = (state_q == S_INIT) || emit_fire;
  assign mem_waddr = (state_q == S_INIT) ? swp_q : AW'(ball_q);
  assign mem_wdata = (state_q == S_INIT) ? ball_rec_t'{vel: V_LAUNCH, strike: now_q}
                                         : calc_res.rec;
  assign mem_re    = (state_q == S_ISSUE);

  bbl_mem #(
    .DEPTH (BALLS_MAX),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(ball_q)),
    .rdata_o (mem_rdata)
  );

  bbl_calc #(
    .BALLS_MAX (BALLS_MAX),
    .LED_COUNT (LED_COUNT)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_pend_q),
    .rec_i       (mem_rdata),
    .now_i       (now_q),
    .ball_i      (ball_q),
    .res_valid_o (calc_vld),
    .res_o       (calc_res)
  );

  // one ball in flight at a time, so a read never meets a pending write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      n_q        <= '0;
      ball_q     <= '0;
      swp_q      <= '0;
      started_q  <= 1'b0;
      rd_pend_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_ball_q <= '0;
      out_pos_q  <= '0;
      out_hue_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == S_ISSUE);
      if (emit_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q  <= in_i.now_ms;
            n_q    <= n_sat;
            ball_q <= '0;
            swp_q  <= '0;
            if (!started_q) begin
              state_q <= S_INIT;
            end else if (n_sat != 4'd0) begin
              state_q <= S_ISSUE;
            end
          end
        end
        S_INIT: begin
          if (swp_q == AW'(BALLS_MAX - 1)) begin
            started_q <= 1'b1;
            state_q   <= (n_q != 4'd0) ? S_ISSUE : S_IDLE;
          end else begin
            swp_q <= swp_q + AW'(1);
          end
        end
        S_ISSUE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (calc_vld) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_ball_q <= ball_q;
            out_pos_q  <= calc_res.pos;
            out_hue_q  <= 8'({5'b0, ball_q} * HUE_STEP);
            out_last_q <= is_last;
            ball_q     <= ball_q + 3'd1;
            state_q    <= is_last ? S_IDLE : S_ISSUE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.ball_index   = out_ball_q;
  assign out_o.led_position = out_pos_q;
  assign out_o.hue          = out_hue_q;
  assign out_o.last         = out_last_q;

  `BBL_ASSERT_NOW(a_calc_in_wait, calc_vld, state_q == S_WAIT, "pipe result outside wait")
  `BBL_ASSERT_NEXT(a_last_to_idle, emit_fire && is_last, state_q == S_IDLE && out_o.last, "tick not ended")
  `BBL_ASSERT_NEXT(a_started_holds, started_q, started_q, "started flag dropped")

endmodule

// File: rtl/bbl_mem.sv
// Ball state memory: one write port, one read port, registered read data.
// Depends on bbl_pkg.
module bbl_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  bbl_pkg::ball_rec_t wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output bbl_pkg::ball_rec_t rdata_o
);
  import bbl_pkg::*;

  ball_rec_t mem_q [DEPTH];
  ball_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bbl_calc.sv
// Five-stage arithmetic pipe for one ball: flight time, ground test, height,
// damping and LED index. Depends on bbl_pkg.
module bbl_calc #(
  parameter int unsigned BALLS_MAX = 8,
  parameter int unsigned LED_COUNT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bbl_pkg::ball_rec_t rec_i,
  input  bbl_pkg::ms_t       now_i,
  input  logic [2:0]         ball_i,
  output logic               res_valid_o,
  output bbl_pkg::calc_res_t res_o
);
  import bbl_pkg::*;

  localparam int unsigned Sq     = BALLS_MAX * BALLS_MAX;
  localparam int unsigned LedMax = LED_COUNT - 1;
  localparam int unsigned PosMax = (LedMax < 255) ? LedMax : 255;

  // restitution per ball: 0.90 - i/BALLS_MAX^2, Q0.16
  logic [15:0] cor_tbl [8];
  for (genvar gi = 0; gi < 8; gi++) begin : g_cor
    localparam int unsigned Dec = (gi * 65536 + Sq / 2) / Sq;
    localparam int unsigned Cor = (Dec >= COR_BASE) ? 0 : COR_BASE - Dec;
    assign cor_tbl[gi] = 16'(Cor);
  end

  logic [4:0] vld_q;

  // stage 1
  ms_t         t;
  logic [28:0] v2000, tsh;
  logic        s1_hit_q;
  logic [12:0] s1_t_q;
  logic [28:0] s1_diff_q;
  vel_t        s1_v_q;
  ms_t         s1_strike_q;
  logic [2:0]  s1_ball_q;

  assign t     = now_i - rec_i.strike;
  assign v2000 = (29'(rec_i.vel) << 11) - (29'(rec_i.vel) << 5) - (29'(rec_i.vel) << 4);
  assign tsh   = {t[12:0], 16'b0};

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_hit_q    <= (|t[31:13]) || (tsh > v2000);
      s1_t_q      <= t[12:0];
      s1_diff_q   <= v2000 - tsh;
      s1_v_q      <= rec_i.vel;
      s1_strike_q <= ((|t[31:13]) || (tsh > v2000)) ? now_i : rec_i.strike;
      s1_ball_q   <= ball_i;
    end
  end

  // stage 2: height numerator and damped velocity product
  logic [41:0] s2_prod_q;
  logic [33:0] s2_vc_q;
  logic        s2_hit_q;
  vel_t        s2_v_q;
  ms_t         s2_strike_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      s2_prod_q   <= 42'(s1_t_q) * 42'(s1_diff_q);
      s2_vc_q     <= 34'(s1_v_q) * 34'(cor_tbl[s1_ball_q]);
      s2_hit_q    <= s1_hit_q;
      s2_v_q      <= s1_v_q;
      s2_strike_q <= s1_strike_q;
    end
  end

  // stage 3: reciprocal estimate of the quotient, velocity update
  logic [30:0] xs;
  logic [62:0] mq;
  logic [33:0] vround;
  vel_t        nv;
  logic [17:0] s3_qe_q;
  logic [30:0] s3_xs_q;
  logic        s3_sat_q;
  logic        s3_hit_q;
  vel_t        s3_v_q;
  ms_t         s3_strike_q;

  assign xs     = s2_prod_q[37:7];
  assign mq     = 63'(xs) * 63'(DIV_M);
  assign vround = s2_vc_q + 34'd32768;
  assign nv     = vround[33:16];

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      s3_qe_q     <= mq[62:45];
      s3_xs_q     <= xs;
      s3_sat_q    <= s2_prod_q >= H_SAT_PROD;
      s3_hit_q    <= s2_hit_q;
      s3_v_q      <= !s2_hit_q ? s2_v_q : ((nv < V_RELAUNCH) ? V_LAUNCH : nv);
      s3_strike_q <= s2_strike_q;
    end
  end

  // stage 4: quotient correction, the estimate is at most one low
  logic [30:0] qm, rem;
  logic [17:0] q;
  logic [16:0] s4_h_q;
  vel_t        s4_v_q;
  ms_t         s4_strike_q;

  assign qm  = 31'(s3_qe_q) * DIV_D;
  assign rem = s3_xs_q - qm;
  assign q   = s3_qe_q + 18'(rem >= DIV_D);

  // on a ground strike the product is meaningless, so the strike wins
  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      s4_h_q      <= s3_hit_q ? 17'd0 : (s3_sat_q ? H_MAX : q[16:0]);
      s4_v_q      <= s3_v_q;
      s4_strike_q <= s3_strike_q;
    end
  end

  // stage 5: LED index with rounding and clamp
  logic [29:0] pm;
  logic [13:0] p;
  calc_res_t   res_q;

  assign pm = 30'(s4_h_q) * 30'(LedMax) + 30'd32768;
  assign p  = pm[29:16];

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      res_q.pos        <= (p > 14'(PosMax)) ? 8'(PosMax) : p[7:0];
      res_q.rec.vel    <= s4_v_q;
      res_q.rec.strike <= s4_strike_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  assign res_valid_o = vld_q[4];
  assign res_o       = res_q;

endmodule
